FILE: rtl/core/edca_backoff_queue_defines.svh
// ----------------------------------------------------------------------------
// EDCA backoff queue assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef EDCA_BACKOFF_QUEUE_DEFINES_SVH
`define EDCA_BACKOFF_QUEUE_DEFINES_SVH

// Checked outside reset only.
`define EBQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define EBQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/core/ebq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDCA backoff queue package
// Action codes, register indexes, field layout and reset values.
// ----------------------------------------------------------------------------
package ebq_pkg;

    typedef enum logic [2:0] {
        ACT_ENQUEUE = 3'd0,
        ACT_IDLE    = 3'd1,
        ACT_TX_OK   = 3'd2,
        ACT_TX_FAIL = 3'd3,
        ACT_COLLIDE = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        CFG_AIFS        = 3'd0,
        CFG_WINDOW_MIN  = 3'd1,
        CFG_WINDOW_MAX  = 3'd2,
        CFG_QUEUE_LIMIT = 3'd3,
        CFG_RTS_THRESH  = 3'd4,
        CFG_SHORT_LIMIT = 3'd5,
        CFG_LONG_LIMIT  = 3'd6
    } cfg_index_t;

    localparam int DEFAULT_QUEUE_DEPTH = 64;

    localparam int ID_W    = 8;
    localparam int LEN_W   = 16;
    localparam int SLOT_W  = 16;
    localparam int WIN_W   = 10;
    localparam int AIFS_W  = 4;
    localparam int RETRY_W = 8;
    localparam int LIMIT_W = 7;
    localparam int CFG_W   = 16;

    localparam logic [AIFS_W-1:0]  RST_AIFS        = 4'd9;
    localparam logic [WIN_W-1:0]   RST_WINDOW_MIN  = 10'd15;
    localparam logic [WIN_W-1:0]   RST_WINDOW_MAX  = 10'd1023;
    localparam logic [LIMIT_W-1:0] RST_QUEUE_LIMIT = 7'd0;
    localparam logic [LEN_W-1:0]   RST_RTS_THRESH  = 16'd2347;
    localparam logic [RETRY_W-1:0] RST_SHORT_LIMIT = 8'd7;
    localparam logic [RETRY_W-1:0] RST_LONG_LIMIT  = 8'd4;
    localparam logic [RETRY_W-1:0] RETRY_MAX       = 8'd255;

    // Input tdata layout
    localparam int S_TDATA_W  = 56;
    localparam int S_PID_LSB  = 0;
    localparam int S_LEN_LSB  = 8;
    localparam int S_KNOWN    = 24;
    localparam int S_SLOT_LSB = 25;
    localparam int S_RND_LSB  = 41;

    // Result tdata layout
    localparam int M_TDATA_W  = 40;
    localparam int M_ACC      = 0;
    localparam int M_ERR      = 1;
    localparam int M_RDY      = 2;
    localparam int M_HEAD_LSB = 3;
    localparam int M_BO_LSB   = 11;
    localparam int M_BO_MSB   = 20;
    localparam int M_WIN_LSB  = 21;
    localparam int M_WIN_MSB  = 30;
    localparam int M_CNT_LSB  = 31;

    typedef struct packed {
        logic            is_long;
        logic [ID_W-1:0] id;
    } entry_t;

endpackage

FILE: rtl/core/ebq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDCA backoff queue packet store
// One write port, one read port with registered read data and write forward.
// ----------------------------------------------------------------------------
module ebq_store #(
    parameter int DEPTH  = ebq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  ebq_pkg::entry_t     wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output ebq_pkg::entry_t     rd_data
);

    ebq_pkg::entry_t mem [DEPTH];
    ebq_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // forward a same-cycle write to the read register
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/edca_backoff_queue.sv
`timescale 1ns / 1ps
// A result is registered on its input transfer and is shown in the next cycle.
// Throughput: one item per cycle while every result transfers; a waiting result blocks the input.
// The store holds the entry behind the head in a read register, so a pop
// finds the next head without a memory read in its cycle.
// Reset (aresetn low, synchronous) clears queue, backoff and retry state and
// loads the register defaults; stored packets need no clearing.
// ----------------------------------------------------------------------------
// EDCA backoff queue
// One access category: packet FIFO, backoff counter, contention window and
// retry counters, updated by one action per transfer.
// ----------------------------------------------------------------------------
module edca_backoff_queue #(
    parameter int QUEUE_DEPTH = ebq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // packet_id, packet_length, idle_known, idle_slots, random_bits
    input  logic [ebq_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [2:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // accepted, error, ready_res, head_packet, backoff_left, window_now,
    // queue_count
    output logic [ebq_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [ebq_pkg::CFG_W-1:0]     cfg_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > ebq_pkg::LIMIT_W) ? CNT_W : ebq_pkg::LIMIT_W;
    localparam int SUM_W = CNT_W + 1;
    localparam int WIN_W = ebq_pkg::WIN_W;
    localparam int RTR_W = ebq_pkg::RETRY_W;

    // configuration
    logic [ebq_pkg::AIFS_W-1:0]  aifs_reg;
    logic [WIN_W-1:0]            wmin_reg;
    logic [WIN_W-1:0]            wmax_reg;
    logic [ebq_pkg::LIMIT_W-1:0] qlimit_reg;
    logic [ebq_pkg::LEN_W-1:0]   rts_reg;
    logic [RTR_W-1:0]            srl_reg;
    logic [RTR_W-1:0]            lrl_reg;

    // queue and channel state
    logic [PTR_W-1:0] hp_reg, hp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIN_W-1:0] backoff_reg, backoff_next;
    logic [WIN_W-1:0] window_reg, window_next;
    logic [RTR_W-1:0] srt_reg, srt_next;
    logic [RTR_W-1:0] lrt_reg, lrt_next;
    ebq_pkg::entry_t  head_reg, head_next;

    logic                          m_tvalid_reg;
    logic [ebq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // fields
    ebq_pkg::action_t            action;
    logic [ebq_pkg::ID_W-1:0]    pid;
    logic [ebq_pkg::LEN_W-1:0]   plen;
    logic                        idle_known;
    logic [ebq_pkg::SLOT_W-1:0]  idle_slots;
    logic [WIN_W-1:0]            rnd;

    logic                   accept;
    logic                   not_empty;
    logic [CMP_W-1:0]       cap;
    logic [CMP_W-1:0]       limit_ext;
    logic [PTR_W-1:0]       hp_inc;
    logic [SUM_W-1:0]       tail_sum;
    logic [PTR_W-1:0]       tail;
    logic [PTR_W-1:0]       rd_addr;
    logic                   wr_en;
    ebq_pkg::entry_t        new_entry;
    ebq_pkg::entry_t        second;
    logic [ebq_pkg::SLOT_W-1:0] passed;
    logic [WIN_W-1:0]       win_grown;
    logic                   res_accepted;
    logic                   res_error;

    function automatic logic [WIN_W-1:0] grow_window(
        input logic [WIN_W-1:0] win,
        input logic [WIN_W-1:0] wmin,
        input logic [WIN_W-1:0] wmax,
        input logic [RTR_W-1:0] srt,
        input logic [RTR_W-1:0] lrt,
        input logic [RTR_W-1:0] srl,
        input logic [RTR_W-1:0] lrl
    );
        logic [WIN_W:0] wide;
        logic [WIN_W-1:0] res;
        wide = {win, 1'b1};
        if ((srt >= srl) || (lrt >= lrl)) begin
            res = wmin;
        end else if (win < wmax) begin
            res = (wide > {1'b0, wmax}) ? wmax : wide[WIN_W-1:0];
        end else begin
            res = win;
        end
        return res;
    endfunction

    assign action     = ebq_pkg::action_t'(s_tuser);
    assign pid        = s_tdata[ebq_pkg::S_PID_LSB +: ebq_pkg::ID_W];
    assign plen       = s_tdata[ebq_pkg::S_LEN_LSB +: ebq_pkg::LEN_W];
    assign idle_known = s_tdata[ebq_pkg::S_KNOWN];
    assign idle_slots = s_tdata[ebq_pkg::S_SLOT_LSB +: ebq_pkg::SLOT_W];
    assign rnd        = s_tdata[ebq_pkg::S_RND_LSB +: WIN_W];

    assign s_tready  = aresetn && (!m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = aresetn;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign not_empty = (cnt_reg != '0);
    assign limit_ext = CMP_W'(qlimit_reg);
    assign cap = ((limit_ext == '0) || (limit_ext > CMP_W'(QUEUE_DEPTH))) ?
                 CMP_W'(QUEUE_DEPTH) : limit_ext;

    assign hp_inc   = (hp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : hp_reg + 1'b1;
    assign tail_sum = SUM_W'(hp_reg) + SUM_W'(cnt_reg);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    assign rd_addr  = (hp_next == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : hp_next + 1'b1;

    assign new_entry.id      = pid;
    assign new_entry.is_long = (plen >= rts_reg);

    ebq_store #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail),
        .wr_data (new_entry),
        .rd_addr (rd_addr),
        .rd_data (second)
    );

    always_comb begin
        hp_next      = hp_reg;
        cnt_next     = cnt_reg;
        backoff_next = backoff_reg;
        window_next  = window_reg;
        srt_next     = srt_reg;
        lrt_next     = lrt_reg;
        head_next    = head_reg;
        wr_en        = 1'b0;
        res_accepted = 1'b0;
        res_error    = 1'b0;
        passed       = idle_slots - ebq_pkg::SLOT_W'(aifs_reg);
        win_grown    = window_reg;
        if (accept) begin
            case (action)
                ebq_pkg::ACT_ENQUEUE: begin
                    if (CMP_W'(cnt_reg) < cap) begin
                        // start at once only on an idle, empty, settled channel
                        if (!(!not_empty && (backoff_reg == '0) && idle_known &&
                              (idle_slots >= ebq_pkg::SLOT_W'(aifs_reg)))) begin
                            backoff_next = rnd & window_reg;
                        end
                        wr_en        = 1'b1;
                        cnt_next     = cnt_reg + 1'b1;
                        res_accepted = 1'b1;
                        if (!not_empty) begin
                            head_next = new_entry;
                        end
                    end
                end
                ebq_pkg::ACT_IDLE: begin
                    if (idle_slots > ebq_pkg::SLOT_W'(aifs_reg)) begin
                        if (passed >= ebq_pkg::SLOT_W'(backoff_reg)) begin
                            backoff_next = '0;
                        end else begin
                            backoff_next = backoff_reg - passed[WIN_W-1:0];
                        end
                    end
                end
                ebq_pkg::ACT_TX_OK: begin
                    if (!not_empty) begin
                        res_error = 1'b1;
                    end else begin
                        hp_next      = hp_inc;
                        cnt_next     = cnt_reg - 1'b1;
                        head_next    = second;
                        window_next  = wmin_reg;
                        backoff_next = rnd & wmin_reg;
                        if (head_reg.is_long) begin
                            lrt_next = '0;
                        end else begin
                            srt_next = '0;
                        end
                    end
                end
                ebq_pkg::ACT_TX_FAIL: begin
                    if (!not_empty) begin
                        res_error = 1'b1;
                    end else begin
                        win_grown    = grow_window(window_reg, wmin_reg, wmax_reg,
                                                   srt_reg, lrt_reg, srl_reg, lrl_reg);
                        window_next  = win_grown;
                        backoff_next = rnd & win_grown;
                    end
                end
                ebq_pkg::ACT_COLLIDE: begin
                    if (!not_empty) begin
                        res_error = 1'b1;
                    end else begin
                        // saturate the retry count that matches the head
                        if (head_reg.is_long) begin
                            if (lrt_reg != ebq_pkg::RETRY_MAX) lrt_next = lrt_reg + 1'b1;
                        end else begin
                            if (srt_reg != ebq_pkg::RETRY_MAX) srt_next = srt_reg + 1'b1;
                        end
                        win_grown    = grow_window(window_reg, wmin_reg, wmax_reg,
                                                   srt_next, lrt_next, srl_reg, lrl_reg);
                        window_next  = win_grown;
                        backoff_next = rnd & win_grown;
                    end
                end
                default: begin
                    res_error = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[ebq_pkg::M_ACC] = res_accepted;
        m_tdata_next[ebq_pkg::M_ERR] = res_error;
        m_tdata_next[ebq_pkg::M_RDY] = (cnt_next != '0) && (backoff_next == '0);
        m_tdata_next[ebq_pkg::M_HEAD_LSB +: ebq_pkg::ID_W] =
            (cnt_next != '0) ? head_next.id : '0;
        m_tdata_next[ebq_pkg::M_BO_LSB +: WIN_W]  = backoff_next;
        m_tdata_next[ebq_pkg::M_WIN_LSB +: WIN_W] = window_next;
        m_tdata_next[ebq_pkg::M_CNT_LSB +: ebq_pkg::LIMIT_W] =
            ebq_pkg::LIMIT_W'(cnt_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aifs_reg   <= ebq_pkg::RST_AIFS;
            wmin_reg   <= ebq_pkg::RST_WINDOW_MIN;
            wmax_reg   <= ebq_pkg::RST_WINDOW_MAX;
            qlimit_reg <= ebq_pkg::RST_QUEUE_LIMIT;
            rts_reg    <= ebq_pkg::RST_RTS_THRESH;
            srl_reg    <= ebq_pkg::RST_SHORT_LIMIT;
            lrl_reg    <= ebq_pkg::RST_LONG_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            case (ebq_pkg::cfg_index_t'(cfg_index))
                ebq_pkg::CFG_AIFS:        aifs_reg   <= cfg_data[ebq_pkg::AIFS_W-1:0];
                ebq_pkg::CFG_WINDOW_MIN:  wmin_reg   <= cfg_data[WIN_W-1:0];
                ebq_pkg::CFG_WINDOW_MAX:  wmax_reg   <= cfg_data[WIN_W-1:0];
                ebq_pkg::CFG_QUEUE_LIMIT: qlimit_reg <= cfg_data[ebq_pkg::LIMIT_W-1:0];
                ebq_pkg::CFG_RTS_THRESH:  rts_reg    <= cfg_data[ebq_pkg::LEN_W-1:0];
                ebq_pkg::CFG_SHORT_LIMIT: srl_reg    <= cfg_data[RTR_W-1:0];
                ebq_pkg::CFG_LONG_LIMIT:  lrl_reg    <= cfg_data[RTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_reg       <= '0;
            cnt_reg      <= '0;
            backoff_reg  <= '0;
            window_reg   <= ebq_pkg::RST_WINDOW_MIN;
            srt_reg      <= '0;
            lrt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            hp_reg      <= hp_next;
            cnt_reg     <= cnt_next;
            backoff_reg <= backoff_next;
            window_reg  <= window_next;
            srt_reg     <= srt_next;
            lrt_reg     <= lrt_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

FILE: rtl/core/ebq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDCA backoff queue port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "edca_backoff_queue_defines.svh"

module ebq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ebq_pkg::M_TDATA_W-1:0] m_tdata
);

    `EBQ_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")
    `EBQ_ASSERT(a_result_next, s_tvalid && s_tready |=> m_tvalid, "transfer gave no result")
    `EBQ_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `EBQ_ASSERT(a_backoff_window, m_tvalid |-> m_tdata[ebq_pkg::M_BO_MSB:ebq_pkg::M_BO_LSB] <= m_tdata[ebq_pkg::M_WIN_MSB:ebq_pkg::M_WIN_LSB], "backoff beyond window")
    `EBQ_ASSERT(a_acc_err, m_tvalid |-> !(m_tdata[ebq_pkg::M_ACC] && m_tdata[ebq_pkg::M_ERR]), "accepted and error together")

endmodule

bind edca_backoff_queue ebq_checker u_ebq_checker (.*);
